// File: rtl/core/afx_pkg.sv
package afx_pkg;

  localparam int OFF_W = 13;

  localparam logic [7:0]       SYNC_BYTE = 8'hFF;
  localparam logic [3:0]       SYNC_NIB  = 4'hF;
  localparam logic [OFF_W-1:0] MIN_LEN   = 13'd6;

  // offsets of the second sync byte, the body start and the length field bytes in the adts header
  localparam logic [OFF_W-1:0] OFF_SYNC2 = 13'd1;
  localparam logic [OFF_W-1:0] OFF_BODY  = 13'd2;
  localparam logic [OFF_W-1:0] OFF_LEN_HI  = 13'd3;
  localparam logic [OFF_W-1:0] OFF_LEN_MID = 13'd4;
  localparam logic [OFF_W-1:0] OFF_LEN_LO  = 13'd5;

  localparam logic [1:0] STATUS_COMPLETE  = 2'd0;
  localparam logic [1:0] STATUS_SHORT     = 2'd1;
  localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

  localparam int QDEPTH = 3;

  typedef struct packed {
    logic [7:0]       data;
    logic [OFF_W-1:0] offset;
    logic [OFF_W-1:0] length;
    logic             last;
    logic [1:0]       status;
  } result_t;

  // results made by one accepted item; second implies first
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

endpackage

// File: rtl/core/afx_parse.sv
module afx_parse (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              end_of_data,
  output afx_pkg::push_t    push,
  output afx_pkg::result_t  res0,
  output afx_pkg::result_t  res1
);

  logic                       in_frame;
  logic                       in_frame_next;
  logic                       held_valid;
  logic                       held_valid_next;
  logic [afx_pkg::OFF_W-1:0]  byte_offset;
  logic [afx_pkg::OFF_W-1:0]  byte_offset_next;
  logic [afx_pkg::OFF_W-1:0]  length_accum;
  logic [afx_pkg::OFF_W-1:0]  length_accum_next;

  always_comb begin
    logic                      sync_hit;
    logic [afx_pkg::OFF_W-1:0] accum_upd;
    logic                      last;
    logic [1:0]                status;
    sync_hit          = held_valid && (data_byte[7:4] == afx_pkg::SYNC_NIB);
    accum_upd         = length_accum;
    last              = 1'b0;
    status            = afx_pkg::STATUS_COMPLETE;
    push              = '0;
    res0              = '0;
    res1              = '0;
    in_frame_next     = in_frame;
    held_valid_next   = held_valid;
    byte_offset_next  = byte_offset;
    length_accum_next = length_accum;

    if (!in_frame) begin
      // hunting: sync emits the held 0xff plus the second sync byte
      res0.data   = afx_pkg::SYNC_BYTE;
      res1.data   = data_byte;
      res1.offset = afx_pkg::OFF_SYNC2;
      if (sync_hit) begin
        push.first  = accept;
        push.second = accept;
        if (end_of_data) begin
          res1.last   = 1'b1;
          res1.status = afx_pkg::STATUS_TRUNCATED;
          held_valid_next = 1'b0;
        end else begin
          in_frame_next     = 1'b1;
          held_valid_next   = 1'b0;
          byte_offset_next  = afx_pkg::OFF_BODY;
          length_accum_next = '0;
        end
      end else if (end_of_data) begin
        held_valid_next = 1'b0;
      end else begin
        held_valid_next = (data_byte == afx_pkg::SYNC_BYTE);
      end
    end else begin
      if (byte_offset == afx_pkg::OFF_LEN_HI) begin
        accum_upd = {data_byte[1:0], 11'd0};
      end else if (byte_offset == afx_pkg::OFF_LEN_MID) begin
        accum_upd = length_accum | {2'd0, data_byte, 3'd0};
      end else if (byte_offset == afx_pkg::OFF_LEN_LO) begin
        accum_upd = length_accum | {10'd0, data_byte[7:5]};
      end
      res0.data   = data_byte;
      res0.offset = byte_offset;
      if (byte_offset >= afx_pkg::OFF_LEN_LO) begin
        res0.length = accum_upd;
        if (accum_upd < afx_pkg::MIN_LEN) begin
          last   = 1'b1;
          status = afx_pkg::STATUS_SHORT;
        end else if (byte_offset + 13'd1 == accum_upd) begin
          last = 1'b1;
        end
      end
      if (!last && end_of_data) begin
        last   = 1'b1;
        status = afx_pkg::STATUS_TRUNCATED;
      end
      res0.last   = last;
      res0.status = status;
      push.first  = accept;
      length_accum_next = accum_upd;
      if (last) begin
        in_frame_next     = 1'b0;
        held_valid_next   = 1'b0;
        byte_offset_next  = '0;
        length_accum_next = '0;
      end else begin
        byte_offset_next = byte_offset + 13'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame     <= 1'b0;
      held_valid   <= 1'b0;
      byte_offset  <= '0;
      length_accum <= '0;
    end else if (accept) begin
      in_frame     <= in_frame_next;
      held_valid   <= held_valid_next;
      byte_offset  <= byte_offset_next;
      length_accum <= length_accum_next;
    end
  end

  a_second_with_first: assert property (@(posedge clk) disable iff (rst)
    push.second |-> push.first)
    else $error("second result without first");

  a_frame_offset_min: assert property (@(posedge clk) disable iff (rst)
    in_frame |-> (byte_offset >= afx_pkg::OFF_BODY))
    else $error("in-frame offset below body start");

  a_sync_enters_frame: assert property (@(posedge clk) disable iff (rst)
    (push.second && !end_of_data) |=> (in_frame && byte_offset == afx_pkg::OFF_BODY))
    else $error("sync did not enter frame");

endmodule

// File: rtl/core/afx_queue.sv
module afx_queue (
  input  logic              clk,
  input  logic              rst,
  input  afx_pkg::push_t    push,
  input  afx_pkg::result_t  res0,
  input  afx_pkg::result_t  res1,
  input  logic              pop,
  output logic              space,
  output logic              head_valid,
  output afx_pkg::result_t  head
);

  afx_pkg::result_t slots      [afx_pkg::QDEPTH];
  afx_pkg::result_t slots_next [afx_pkg::QDEPTH];
  logic [1:0]       count;
  logic [1:0]       count_next;
  logic [1:0]       count_base;

  assign head_valid = (count != 2'd0);
  assign head       = slots[0];
  // room for two results whatever happens on the output side
  assign space      = (count < 2'd2);

  always_comb begin
    logic [1:0] src;
    count_base = count - {1'b0, pop};
    count_next = count_base + {1'b0, push.first} + {1'b0, push.second};
    for (int i = 0; i < afx_pkg::QDEPTH; i++) begin
      src = 2'(i) + {1'b0, pop};
      if (2'(i) < count_base) begin
        slots_next[i] = slots[src];
      end else if (2'(i) == count_base) begin
        slots_next[i] = res0;
      end else begin
        slots_next[i] = res1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < afx_pkg::QDEPTH; i++) begin
      slots[i] <= slots_next[i];
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.second |-> (count - {1'b0, pop} <= 2'd1))
    else $error("result queue overflow");

  a_pop_only_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (pop && !push.first) |=> (count == $past(count) - 2'd1))
    else $error("queue count did not drop on pop");

endmodule

// File: rtl/core/adts_frame_extractor.sv
// adts frame extractor: takes an aac adts byte stream one item per clock on
// in_valid/in_ready and returns the bytes of each frame found, with offset,
// decoded 13-bit length (from offset 5 on), last flag and a status on the
// last byte (complete, length below 6, or truncated by end_of_data). bytes
// seen while hunting are dropped; a held 0xff followed by a byte with high
// nibble f starts a frame and both sync bytes are queued together. an item is
// processed in the cycle it is accepted and its results are registered into a
// three-entry result queue whose head drives the outputs. the block takes one
// item per clock while out_ready is high; the sync item makes two results, and
// the item after it waits while the queue drains back to a single entry.
// in_ready depends only on the queue fill, never on out_ready in the same
// cycle.
module adts_frame_extractor (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                data_byte,
  input  logic                      end_of_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                out_byte,
  output logic [afx_pkg::OFF_W-1:0] frame_offset,
  output logic [afx_pkg::OFF_W-1:0] frame_length,
  output logic                      frame_last,
  output logic [1:0]                frame_status
);

  logic             accept;
  logic             pop;
  logic             space;
  afx_pkg::push_t   push;
  afx_pkg::result_t res0;
  afx_pkg::result_t res1;
  afx_pkg::result_t head;

  // input side
  assign in_ready = space;
  assign accept   = in_valid && in_ready;

  // frame parsing and state
  afx_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .data_byte   (data_byte),
    .end_of_data (end_of_data),
    .push        (push),
    .res0        (res0),
    .res1        (res1)
  );

  // result queue between the two sides
  afx_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .res0       (res0),
    .res1       (res1),
    .pop        (pop),
    .space      (space),
    .head_valid (out_valid),
    .head       (head)
  );

  // output side
  assign pop          = out_valid && out_ready;
  assign out_byte     = head.data;
  assign frame_offset = head.offset;
  assign frame_length = head.length;
  assign frame_last   = head.last;
  assign frame_status = head.status;

endmodule
